// ===== design/address_range_breakpoint_unit_top_defines.svh =====
// Assertion macros shared by the address range breakpoint unit.
`ifndef ADDRESS_RANGE_BREAKPOINT_UNIT_TOP_DEFINES_SVH
`define ADDRESS_RANGE_BREAKPOINT_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ARBU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ARBU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/arbu_pkg.sv =====
// Shared types and constants of the address range breakpoint unit.
package arbu_pkg;

   localparam int ADDR_W         = 16;
   localparam int OPC_W          = 3;
   localparam int KIND_W         = 2;
   localparam int DEFAULT_RANGES = 8;

   typedef enum logic [OPC_W-1:0] {
      OP_ADD   = 3'd0,
      OP_FLUSH = 3'd1,
      OP_PC    = 3'd2,
      OP_READ  = 3'd3,
      OP_WRITE = 3'd4,
      OP_TEST  = 3'd5
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_PC    = 2'd2
   } kind_type;

   typedef struct packed {
      logic load_item;
      logic commit;
   } ctl_cmd_type;

endpackage

// ===== design/arbu_ctrl.sv =====
// Controller state machine: handshakes and sequencing of one command at a time.
module arbu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output arbu_pkg::ctl_cmd_type cmd
);
   import arbu_pkg::*;
`include "address_range_breakpoint_unit_top_defines.svh"

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall     = (state_ff != S_IDLE);
   assign cmd.load_item = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit    = (state_ff == S_EXEC) && out_free;
   assign rsp_valid     = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ARBU_ASSERT_NEXT(a_accept_then_exec, req_valid && !req_stall, state_ff == S_EXEC, "accepted beat did not start execution")
   `ARBU_ASSERT_NOW(a_no_commit_when_full, rsp_valid_ff && rsp_stall, !cmd.commit, "result overwritten while stalled")
   `ARBU_ASSERT_NEXT(a_commit_gives_result, cmd.commit, rsp_valid_ff, "committed result not presented")
endmodule

// ===== design/arbu_datapath.sv =====
// Datapath: range tables, parallel range comparators, pending flag and result register.
module arbu_datapath #(
   parameter int RANGES_PER_TABLE = arbu_pkg::DEFAULT_RANGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  arbu_pkg::ctl_cmd_type       cmd,
   input  logic [arbu_pkg::OPC_W-1:0]  req_opcode,
   input  logic [arbu_pkg::KIND_W-1:0] req_bp_kind,
   input  logic [arbu_pkg::ADDR_W-1:0] req_range_low,
   input  logic [arbu_pkg::ADDR_W-1:0] req_range_high,
   input  logic [arbu_pkg::ADDR_W-1:0] req_address,
   input  logic                        req_preexec,
   output logic                        rsp_break_now,
   output logic [arbu_pkg::ADDR_W-1:0] rsp_break_address,
   output logic                        rsp_pending_after,
   output logic                        rsp_add_rejected
);
   import arbu_pkg::*;
`include "address_range_breakpoint_unit_top_defines.svh"

   localparam int CNT_W = $clog2(RANGES_PER_TABLE + 1);
   localparam int IDX_W = (RANGES_PER_TABLE > 1) ? $clog2(RANGES_PER_TABLE) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(RANGES_PER_TABLE);

   logic [OPC_W-1:0]  opcode_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [ADDR_W-1:0] lo_ff, hi_ff, addr_ff;
   logic              pre_ff;

   logic [ADDR_W-1:0] pc_lo_ff [RANGES_PER_TABLE];
   logic [ADDR_W-1:0] pc_hi_ff [RANGES_PER_TABLE];
   logic [ADDR_W-1:0] rd_lo_ff [RANGES_PER_TABLE];
   logic [ADDR_W-1:0] rd_hi_ff [RANGES_PER_TABLE];
   logic [ADDR_W-1:0] wr_lo_ff [RANGES_PER_TABLE];
   logic [ADDR_W-1:0] wr_hi_ff [RANGES_PER_TABLE];

   logic [CNT_W-1:0] pc_cnt_ff, pc_cnt_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0] wr_cnt_ff, wr_cnt_in;
   logic             pending_ff, pending_in;

   logic              brk_ff, brk_in;
   logic [ADDR_W-1:0] baddr_ff, baddr_in;
   logic              rej_ff, rej_in;

   logic [RANGES_PER_TABLE-1:0] pc_match, rd_match, wr_match;
   logic pc_hit, rd_hit, wr_hit;
   logic pc_we, rd_we, wr_we;
   logic [CNT_W-1:0] sel_cnt;
   logic             sel_full;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         opcode_ff <= req_opcode;
         kind_ff   <= req_bp_kind;
         lo_ff     <= req_range_low;
         hi_ff     <= req_range_high;
         addr_ff   <= req_address;
         pre_ff    <= req_preexec;
      end
   end

   always_comb begin
      for (int i = 0; i < RANGES_PER_TABLE; i++) begin
         pc_match[i] = (CNT_W'(i) < pc_cnt_ff) && (addr_ff >= pc_lo_ff[i])
                       && (addr_ff <= pc_hi_ff[i]);
         rd_match[i] = (CNT_W'(i) < rd_cnt_ff) && (addr_ff >= rd_lo_ff[i])
                       && (addr_ff <= rd_hi_ff[i]);
         wr_match[i] = (CNT_W'(i) < wr_cnt_ff) && (addr_ff >= wr_lo_ff[i])
                       && (addr_ff <= wr_hi_ff[i]);
      end
   end

   assign pc_hit = |pc_match;
   assign rd_hit = |rd_match;
   assign wr_hit = |wr_match;

   always_comb begin
      case (kind_type'(kind_ff))
         KIND_READ:  sel_cnt = rd_cnt_ff;
         KIND_WRITE: sel_cnt = wr_cnt_ff;
         KIND_PC:    sel_cnt = pc_cnt_ff;
         default:    sel_cnt = '0;
      endcase
   end

   assign sel_full = (sel_cnt >= CNT_MAX);

   always_comb begin
      pc_cnt_in  = pc_cnt_ff;
      rd_cnt_in  = rd_cnt_ff;
      wr_cnt_in  = wr_cnt_ff;
      pending_in = pending_ff;
      pc_we      = 1'b0;
      rd_we      = 1'b0;
      wr_we      = 1'b0;
      brk_in     = 1'b0;
      rej_in     = 1'b0;
      case (opcode_type'(opcode_ff))
         OP_ADD: begin
            case (kind_type'(kind_ff))
               KIND_READ: begin
                  rej_in = sel_full;
                  rd_we  = !sel_full;
                  if (!sel_full) rd_cnt_in = rd_cnt_ff + 1'b1;
               end
               KIND_WRITE: begin
                  rej_in = sel_full;
                  wr_we  = !sel_full;
                  if (!sel_full) wr_cnt_in = wr_cnt_ff + 1'b1;
               end
               KIND_PC: begin
                  rej_in = sel_full;
                  pc_we  = !sel_full;
                  if (!sel_full) pc_cnt_in = pc_cnt_ff + 1'b1;
               end
               default: rej_in = 1'b0;
            endcase
         end
         OP_FLUSH: begin
            case (kind_type'(kind_ff))
               KIND_READ:  rd_cnt_in = '0;
               KIND_WRITE: wr_cnt_in = '0;
               KIND_PC:    pc_cnt_in = '0;
               default:    rej_in = 1'b0;
            endcase
         end
         OP_PC: begin
            brk_in = !pending_ff && pc_hit;
         end
         OP_READ: begin
            if (pre_ff && rd_hit) pending_in = 1'b1;
         end
         OP_WRITE: begin
            if (pre_ff && wr_hit) pending_in = 1'b1;
         end
         OP_TEST: begin
            brk_in     = pending_ff;
            pending_in = 1'b0;
         end
         default: brk_in = 1'b0;
      endcase
      baddr_in = brk_in ? addr_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && pc_we) begin
         pc_lo_ff[pc_cnt_ff[IDX_W-1:0]] <= lo_ff;
         pc_hi_ff[pc_cnt_ff[IDX_W-1:0]] <= hi_ff;
      end
      if (cmd.commit && rd_we) begin
         rd_lo_ff[rd_cnt_ff[IDX_W-1:0]] <= lo_ff;
         rd_hi_ff[rd_cnt_ff[IDX_W-1:0]] <= hi_ff;
      end
      if (cmd.commit && wr_we) begin
         wr_lo_ff[wr_cnt_ff[IDX_W-1:0]] <= lo_ff;
         wr_hi_ff[wr_cnt_ff[IDX_W-1:0]] <= hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_cnt_ff  <= '0;
         rd_cnt_ff  <= '0;
         wr_cnt_ff  <= '0;
         pending_ff <= 1'b0;
      end else if (cmd.commit) begin
         pc_cnt_ff  <= pc_cnt_in;
         rd_cnt_ff  <= rd_cnt_in;
         wr_cnt_ff  <= wr_cnt_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         brk_ff   <= brk_in;
         baddr_ff <= baddr_in;
         rej_ff   <= rej_in;
      end
   end

   assign rsp_break_now     = brk_ff;
   assign rsp_break_address = baddr_ff;
   assign rsp_pending_after = pending_ff;
   assign rsp_add_rejected  = rej_ff;

   `ARBU_ASSERT_NOW(a_counts_bounded, 1'b1, (pc_cnt_ff <= CNT_MAX) && (rd_cnt_ff <= CNT_MAX) && (wr_cnt_ff <= CNT_MAX), "table count beyond capacity")
   `ARBU_ASSERT_NOW(a_single_table_write, 1'b1, $onehot0({pc_we, rd_we, wr_we}), "add wrote more than one table")
endmodule

// ===== design/address_range_breakpoint_unit_top.sv =====
// Address range breakpoint unit: three range tables compared in parallel per event.
// One command is taken at a time: an accepted beat enters execution in the next cycle,
// commits once the result register is free and then presents its result beat.
// A new command is taken only once the previous one has committed, set by the controller;
// a waiting result does not block acceptance, only the next commit.
// Synchronous reset empties all tables and clears the pending flag; entries are not cleared.
module address_range_breakpoint_unit_top #(
   parameter int RANGES_PER_TABLE = arbu_pkg::DEFAULT_RANGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [arbu_pkg::OPC_W-1:0]  req_opcode,
   input  logic [arbu_pkg::KIND_W-1:0] req_bp_kind,
   input  logic [arbu_pkg::ADDR_W-1:0] req_range_low,
   input  logic [arbu_pkg::ADDR_W-1:0] req_range_high,
   input  logic [arbu_pkg::ADDR_W-1:0] req_address,
   input  logic                        req_preexec,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_break_now,
   output logic [arbu_pkg::ADDR_W-1:0] rsp_break_address,
   output logic                        rsp_pending_after,
   output logic                        rsp_add_rejected
);
   import arbu_pkg::*;

   ctl_cmd_type cmd;

   arbu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   arbu_datapath #(
      .RANGES_PER_TABLE (RANGES_PER_TABLE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_bp_kind       (req_bp_kind),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_address       (req_address),
      .req_preexec       (req_preexec),
      .rsp_break_now     (rsp_break_now),
      .rsp_break_address (rsp_break_address),
      .rsp_pending_after (rsp_pending_after),
      .rsp_add_rejected  (rsp_add_rejected)
   );
endmodule

// ===== verif/address_range_breakpoint_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each result beat of the breakpoint unit and compares it field by field.
module address_range_breakpoint_unit_checker #(
   parameter int RANGES = arbu_pkg::DEFAULT_RANGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [arbu_pkg::OPC_W-1:0]  req_opcode,
   input  logic [arbu_pkg::KIND_W-1:0] req_bp_kind,
   input  logic [arbu_pkg::ADDR_W-1:0] req_range_low,
   input  logic [arbu_pkg::ADDR_W-1:0] req_range_high,
   input  logic [arbu_pkg::ADDR_W-1:0] req_address,
   input  logic                        req_preexec,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_break_now,
   input  logic [arbu_pkg::ADDR_W-1:0] rsp_break_address,
   input  logic                        rsp_pending_after,
   input  logic                        rsp_add_rejected,
   output int                          mismatch_count,
   output int                          awaiting_count
);
   import arbu_pkg::*;

   localparam int EXPECT_DEPTH = 16;

   typedef struct packed {
      logic              break_now;
      logic [ADDR_W-1:0] break_address;
      logic              pending_after;
      logic              add_rejected;
   } break_result_type;

   logic [ADDR_W-1:0] range_lo [3][RANGES];
   logic [ADDR_W-1:0] range_hi [3][RANGES];
   int unsigned       range_count [3];
   bit                access_pending;
   break_result_type  expected_results [EXPECT_DEPTH];
   int                expect_head  = 0;
   int                expect_tail  = 0;
   int                expect_level = 0;

   function automatic bit range_hit(input int tbl, input logic [ADDR_W-1:0] addr);
      for (int i = 0; i < range_count[tbl] && i < RANGES; i++) begin
         if (addr >= range_lo[tbl][i] && addr <= range_hi[tbl][i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic break_result_type predict_break(
      input logic [OPC_W-1:0]  opcode,
      input logic [KIND_W-1:0] kind,
      input logic [ADDR_W-1:0] lo,
      input logic [ADDR_W-1:0] hi,
      input logic [ADDR_W-1:0] addr,
      input logic              pre
   );
      break_result_type r;
      r = '0;
      case (opcode)
         OP_ADD: begin
            if (kind <= KIND_PC) begin
               if (range_count[kind] >= RANGES) begin
                  r.add_rejected = 1'b1;
               end else begin
                  range_lo[kind][range_count[kind]] = lo;
                  range_hi[kind][range_count[kind]] = hi;
                  range_count[kind]++;
               end
            end
         end
         OP_FLUSH: begin
            if (kind <= KIND_PC) range_count[kind] = 0;
         end
         OP_PC: begin
            if (!access_pending && range_hit(KIND_PC, addr)) begin
               r.break_now     = 1'b1;
               r.break_address = addr;
            end
         end
         OP_READ: begin
            if (pre && range_hit(KIND_READ, addr)) access_pending = 1'b1;
         end
         OP_WRITE: begin
            if (pre && range_hit(KIND_WRITE, addr)) access_pending = 1'b1;
         end
         OP_TEST: begin
            if (access_pending) begin
               r.break_now     = 1'b1;
               r.break_address = addr;
            end
            access_pending = 1'b0;
         end
         default: begin
         end
      endcase
      r.pending_after = access_pending;
      return r;
   endfunction

   always @(posedge clock) begin
      break_result_type seen;
      break_result_type want;
      break_result_type fresh;
      if (reset) begin
         range_count    = '{0, 0, 0};
         access_pending = 1'b0;
         mismatch_count = 0;
         expect_head    = 0;
         expect_tail    = 0;
         expect_level   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_break_now, rsp_break_address, rsp_pending_after, rsp_add_rejected};
            if (expect_level == 0) begin
               mismatch_count++;
               $display("%0t: result beat with none expected: actual %0b/%h/%0b/%0b", $time,
                        seen.break_now, seen.break_address, seen.pending_after,
                        seen.add_rejected);
            end else begin
               want         = expected_results[expect_head];
               expect_head  = (expect_head + 1) % EXPECT_DEPTH;
               expect_level = expect_level - 1;
               if (seen !== want) begin
                  mismatch_count++;
                  $display(
                     "%0t: mismatch brk/addr/pend/rej: expected %0b/%h/%0b/%0b, actual %0b/%h/%0b/%0b",
                     $time, want.break_now, want.break_address, want.pending_after,
                     want.add_rejected, seen.break_now, seen.break_address,
                     seen.pending_after, seen.add_rejected);
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh = predict_break(req_opcode, req_bp_kind, req_range_low, req_range_high,
                                  req_address, req_preexec);
            if (expect_level == EXPECT_DEPTH) begin
               mismatch_count++;
               $display("%0t: too many beats in flight: expected at most %0d, actual %0d",
                        $time, EXPECT_DEPTH, expect_level + 1);
            end else begin
               expected_results[expect_tail] = fresh;
               expect_tail  = (expect_tail + 1) % EXPECT_DEPTH;
               expect_level = expect_level + 1;
            end
         end
      end
      awaiting_count = expect_level;
   end

endmodule

// ===== verif/address_range_breakpoint_unit_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top that drives command beats into the breakpoint unit and gives the verdict.
module address_range_breakpoint_unit_top_tb;
   import arbu_pkg::*;

   localparam logic [OPC_W-1:0]  OP_SPARE_LO      = 3'd6;
   localparam logic [OPC_W-1:0]  OP_SPARE_HI      = 3'd7;
   localparam logic [KIND_W-1:0] KIND_NONE        = 2'd3;
   localparam int                RANDOM_PER_PHASE = 460;
   localparam int                CYCLE_LIMIT      = 200000;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [OPC_W-1:0]  req_opcode     = '0;
   logic [KIND_W-1:0] req_bp_kind    = '0;
   logic [ADDR_W-1:0] req_range_low  = '0;
   logic [ADDR_W-1:0] req_range_high = '0;
   logic [ADDR_W-1:0] req_address    = '0;
   logic              req_preexec    = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic              rsp_break_now;
   logic [ADDR_W-1:0] rsp_break_address;
   logic              rsp_pending_after;
   logic              rsp_add_rejected;

   int                mismatch_count;
   int                awaiting_count;
   int                idle_pct    = 0;
   int                stall_pct   = 0;
   int                cycle_count = 0;
   logic [ADDR_W-1:0] recent_bounds [16];
   int                bound_slot  = 0;

   address_range_breakpoint_unit_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_bp_kind       (req_bp_kind),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_address       (req_address),
      .req_preexec       (req_preexec),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_break_now     (rsp_break_now),
      .rsp_break_address (rsp_break_address),
      .rsp_pending_after (rsp_pending_after),
      .rsp_add_rejected  (rsp_add_rejected)
   );

   address_range_breakpoint_unit_checker break_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_bp_kind       (req_bp_kind),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_address       (req_address),
      .req_preexec       (req_preexec),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_break_now     (rsp_break_now),
      .rsp_break_address (rsp_break_address),
      .rsp_pending_after (rsp_pending_after),
      .rsp_add_rejected  (rsp_add_rejected),
      .mismatch_count    (mismatch_count),
      .awaiting_count    (awaiting_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic issue(
      input logic [OPC_W-1:0]  op,
      input logic [KIND_W-1:0] kind,
      input logic [ADDR_W-1:0] lo,
      input logic [ADDR_W-1:0] hi,
      input logic [ADDR_W-1:0] addr,
      input logic              pre
   );
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_bp_kind    <= kind;
      req_range_low  <= lo;
      req_range_high <= hi;
      req_address    <= addr;
      req_preexec    <= pre;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue_random();
      int                sel;
      int                shape;
      logic [OPC_W-1:0]  op;
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] addr;
      logic              pre;
      sel = $urandom_range(99);
      if ($urandom_range(19) == 0) kind = KIND_NONE;
      else kind = KIND_W'($urandom_range(2));
      lo  = ADDR_W'($urandom);
      hi  = ADDR_W'($urandom);
      pre = ($urandom_range(4) != 0);
      // Most events land on or next to a bound that was recently added.
      if ($urandom_range(9) < 6) begin
         addr = ADDR_W'(recent_bounds[$urandom_range(15)] + $urandom_range(2) - 1);
      end else begin
         addr = ADDR_W'($urandom);
      end
      if (sel < 15) begin
         op    = OP_ADD;
         shape = $urandom_range(5);
         if (shape == 0) begin
            hi = lo;
         end else if (shape < 4) begin
            hi = ADDR_W'(lo + $urandom_range(255));
         end else if (shape == 4) begin
            if ($urandom_range(1)) lo = '0;
            else hi = '1;
         end
         recent_bounds[bound_slot]     = lo;
         recent_bounds[bound_slot + 1] = hi;
         bound_slot = (bound_slot + 2) % 16;
      end else if (sel < 18) begin
         op = OP_FLUSH;
      end else if (sel < 42) begin
         op = OP_PC;
      end else if (sel < 62) begin
         op = OP_READ;
      end else if (sel < 82) begin
         op = OP_WRITE;
      end else if (sel < 97) begin
         op = OP_TEST;
      end else if ($urandom_range(1)) begin
         op = OP_SPARE_LO;
      end else begin
         op = OP_SPARE_HI;
      end
      issue(op, kind, lo, hi, addr, pre);
   endtask

   initial begin
      foreach (recent_bounds[i]) recent_bounds[i] = ADDR_W'($urandom);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue(OP_PC,       KIND_PC,   16'h0000, 16'h0000, 16'h0000, 1'b1);
      issue(OP_TEST,     KIND_READ, 16'h0000, 16'h0000, 16'h1234, 1'b1);
      issue(OP_ADD,      KIND_NONE, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
      issue(OP_FLUSH,    KIND_NONE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
      issue(OP_SPARE_LO, KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      issue(OP_SPARE_HI, KIND_PC,   16'h0000, 16'h0000, 16'h0000, 1'b0);
      issue(OP_ADD,      KIND_PC,   16'h1000, 16'h1FFF, 16'h0000, 1'b0);
      issue(OP_ADD,      KIND_PC,   16'h5000, 16'h4000, 16'h0000, 1'b0);
      issue(OP_ADD,      KIND_PC,   16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      issue(OP_ADD,      KIND_PC,   16'h0000, 16'h0000, 16'h0000, 1'b0);
      issue(OP_PC,       KIND_PC,   16'h0000, 16'h0000, 16'h1000, 1'b1);
      issue(OP_PC,       KIND_PC,   16'h0000, 16'h0000, 16'h4800, 1'b1);
      issue(OP_PC,       KIND_PC,   16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      issue(OP_ADD,      KIND_READ, 16'h8000, 16'h80FF, 16'h0000, 1'b1);
      issue(OP_READ,     KIND_READ, 16'h0000, 16'h0000, 16'h8010, 1'b0);
      issue(OP_READ,     KIND_READ, 16'h0000, 16'h0000, 16'h80FF, 1'b1);
      issue(OP_PC,       KIND_PC,   16'h0000, 16'h0000, 16'h0000, 1'b1);
      issue(OP_TEST,     KIND_READ, 16'h0000, 16'h0000, 16'hABCD, 1'b1);
      issue(OP_ADD,      KIND_WRITE, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
      issue(OP_WRITE,    KIND_WRITE, 16'h0000, 16'h0000, 16'h1234, 1'b1);
      issue(OP_TEST,     KIND_WRITE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
      for (int i = 0; i < 5; i++) begin
         issue(OP_ADD, KIND_PC, ADDR_W'(16'h2000 * i), ADDR_W'(16'h2000 * i + 16'h00FF),
               16'h0000, 1'b1);
      end
      issue(OP_FLUSH,    KIND_PC,   16'h0000, 16'h0000, 16'h0000, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 65;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 65;
            end
            default: begin
               idle_pct  = 10;
               stall_pct = 10;
            end
         endcase
         repeat (RANDOM_PER_PHASE) issue_random();
      end
      req_valid <= 1'b0;

      wait (awaiting_count == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
